// ----- design/btp_pkg.sv -----
// Shared types and codes for the BER-TLV stream parser.
// No dependencies; every other design file but btp_fifo refers to it by scoped names.
package btp_pkg;

    localparam int BYTE_W   = 8;
    localparam int VAL_W    = 24;
    localparam int LIM_W    = 2;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_LIMIT = 1'd1;

    // byte_kind codes
    localparam logic [1:0] KIND_TAG     = 2'd0;
    localparam logic [1:0] KIND_LENGTH  = 2'd1;
    localparam logic [1:0] KIND_VALUE   = 2'd2;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    // error_code codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TAG_LONG  = 3'd1;
    localparam logic [2:0] ERR_INDEF     = 3'd2;
    localparam logic [2:0] ERR_LEN_BYTES = 3'd3;
    localparam logic [2:0] ERR_TRUNC     = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_last;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [1:0]        byte_kind;
        logic              element_start;
        logic              tag_complete;
        logic [VAL_W-1:0]  tag_value;
        logic              constructed;
        logic              length_complete;
        logic [VAL_W-1:0]  length_value;
        logic              element_end;
        logic [2:0]        error_code;
        logic              buffer_done;
    } t_out_item;

    // byte after decode by the front end
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              tag_multi;  // low five bits all ones
        logic              cont;       // bit 7
        logic              cons_bit;   // bit 5
        logic              len_indef;  // exactly 0x80
        logic              len_over;   // long form count above the limit
        logic [1:0]        len_left;   // long form count minus one
    } t_cls_item;

endpackage

// ----- design/btp_fifo.sv -----
// Small register queue used between the parser stages and at the result side.
// Generic width; no package dependency.
module btp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- design/btp_front.sv -----
// Front end: holds the limit registers and decodes each raw byte.
// Uses btp_pkg types; feeds the decode queue in front of btp_back.
module btp_front #(
    parameter int TAG_BYTES_MAX    = 3,
    parameter int LENGTH_BYTES_MAX = 3
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [btp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [btp_pkg::LIM_W-1:0]        i_cfg_data,
    input  btp_pkg::t_in_item                i_item,
    output btp_pkg::t_cls_item               o_cls,
    output logic [btp_pkg::LIM_W-1:0]        o_tag_lim
);
    logic [btp_pkg::LIM_W-1:0] r_tag_reg, r_len_reg;
    logic [btp_pkg::LIM_W-1:0] len_lim;
    logic [6:0]                n_cnt;

    // register raised to one if zero, then capped
    function automatic logic [btp_pkg::LIM_W-1:0] eff_limit(
        input logic [btp_pkg::LIM_W-1:0] reg_val,
        input logic [btp_pkg::LIM_W:0]   cap
    );
        logic [btp_pkg::LIM_W:0] r;
        r = (reg_val == '0) ? (btp_pkg::LIM_W+1)'(1) : {1'b0, reg_val};
        if (r > cap) begin
            r = cap;
        end
        return r[btp_pkg::LIM_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_reg <= btp_pkg::LIM_W'(3);
            r_len_reg <= btp_pkg::LIM_W'(3);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                btp_pkg::CFG_TAG_LIMIT: r_tag_reg <= i_cfg_data;
                btp_pkg::CFG_LEN_LIMIT: r_len_reg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_tag_lim = eff_limit(r_tag_reg, (btp_pkg::LIM_W+1)'(TAG_BYTES_MAX));
    assign len_lim   = eff_limit(r_len_reg, (btp_pkg::LIM_W+1)'(LENGTH_BYTES_MAX));
    assign n_cnt     = i_item.in_byte[6:0];

    always_comb begin
        o_cls.data      = i_item.in_byte;
        o_cls.last      = i_item.in_last;
        o_cls.tag_multi = (i_item.in_byte[4:0] == 5'h1F);
        o_cls.cont      = i_item.in_byte[7];
        o_cls.cons_bit  = i_item.in_byte[5];
        o_cls.len_indef = (i_item.in_byte == 8'h80);
        o_cls.len_over  = (n_cnt > {5'd0, len_lim});
        o_cls.len_left  = 2'(n_cnt - 7'd1);
    end

endmodule

// ----- design/btp_back.sv -----
// Back end: TLV state machine, one decoded byte per cycle into a result item
// while the result queue has room. Uses btp_pkg types and codes.
module btp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  btp_pkg::t_cls_item            i_cls,
    input  logic [btp_pkg::LIM_W-1:0]     i_tag_lim,
    output logic                          o_take,
    input  logic                          i_res_full,
    output btp_pkg::t_out_item            o_res
);
    typedef enum logic [2:0] {
        PH_TAG0, PH_TAGN, PH_LEN0, PH_LENN, PH_VAL, PH_ERR
    } t_phase;

    t_phase                     r_phase, n_phase;
    logic [btp_pkg::VAL_W-1:0]  r_tag_acc, n_tag_acc;
    logic [1:0]                 r_tag_cnt, n_tag_cnt;
    logic                       r_cons, n_cons;
    logic [btp_pkg::VAL_W-1:0]  r_len_acc, n_len_acc;
    logic [1:0]                 r_len_left, n_len_left;
    logic [btp_pkg::VAL_W-1:0]  r_val_left, n_val_left;
    logic [2:0]                 r_err, n_err;
    logic                       have_len;
    logic [btp_pkg::VAL_W-1:0]  lval;

    assign o_take = i_valid && !i_res_full;

    always_comb begin
        n_phase    = r_phase;
        n_tag_acc  = r_tag_acc;
        n_tag_cnt  = r_tag_cnt;
        n_cons     = r_cons;
        n_len_acc  = r_len_acc;
        n_len_left = r_len_left;
        n_val_left = r_val_left;
        n_err      = r_err;
        have_len   = 1'b0;
        lval       = '0;

        o_res                 = '0;
        o_res.out_byte        = i_cls.data;
        o_res.byte_kind       = btp_pkg::KIND_IGNORED;
        o_res.buffer_done     = i_cls.last;

        unique case (r_phase)
            PH_TAG0: begin
                o_res.byte_kind     = btp_pkg::KIND_TAG;
                o_res.element_start = 1'b1;
                n_tag_acc           = {16'd0, i_cls.data};
                n_tag_cnt           = '0;
                n_cons              = i_cls.cons_bit;
                o_res.constructed   = i_cls.cons_bit;
                if (i_cls.tag_multi) begin
                    if (i_tag_lim <= 2'd1) begin
                        n_err = btp_pkg::ERR_TAG_LONG;
                    end else begin
                        n_phase = PH_TAGN;
                    end
                end else begin
                    o_res.tag_complete = 1'b1;
                    n_phase            = PH_LEN0;
                end
            end
            PH_TAGN: begin
                o_res.byte_kind   = btp_pkg::KIND_TAG;
                o_res.constructed = r_cons;
                n_tag_acc         = {r_tag_acc[15:0], i_cls.data};
                if (i_cls.cont) begin
                    if ({1'b0, r_tag_cnt} + 3'd2 >= {1'b0, i_tag_lim}) begin
                        n_err = btp_pkg::ERR_TAG_LONG;
                    end else begin
                        n_tag_cnt = r_tag_cnt + 2'd1;
                    end
                end else begin
                    o_res.tag_complete = 1'b1;
                    n_phase            = PH_LEN0;
                end
            end
            PH_LEN0: begin
                o_res.byte_kind   = btp_pkg::KIND_LENGTH;
                o_res.constructed = r_cons;
                if (!i_cls.cont) begin
                    lval     = {16'd0, i_cls.data};
                    have_len = 1'b1;
                end else if (i_cls.len_indef) begin
                    n_err = btp_pkg::ERR_INDEF;
                end else if (i_cls.len_over) begin
                    n_err = btp_pkg::ERR_LEN_BYTES;
                end else begin
                    n_len_left = i_cls.len_left;
                    n_len_acc  = '0;
                    n_phase    = PH_LENN;
                end
            end
            PH_LENN: begin
                o_res.byte_kind   = btp_pkg::KIND_LENGTH;
                o_res.constructed = r_cons;
                // saturate once a fourth byte would push past 24 bits
                if (r_len_acc[23:16] != 8'd0) begin
                    n_len_acc = '1;
                end else begin
                    n_len_acc = {r_len_acc[15:0], i_cls.data};
                end
                if (r_len_left == 2'd0) begin
                    lval     = n_len_acc;
                    have_len = 1'b1;
                end else begin
                    n_len_left = r_len_left - 2'd1;
                end
            end
            PH_VAL: begin
                o_res.byte_kind   = btp_pkg::KIND_VALUE;
                o_res.constructed = r_cons;
                if (r_val_left <= 24'd1) begin
                    n_val_left        = '0;
                    o_res.element_end = 1'b1;
                    n_phase           = PH_TAG0;
                end else begin
                    n_val_left = r_val_left - 24'd1;
                end
            end
            PH_ERR: ;
            default: ;
        endcase

        if (o_res.tag_complete) begin
            o_res.tag_value = n_tag_acc;
        end

        if (have_len) begin
            o_res.length_complete = 1'b1;
            o_res.length_value    = lval;
            if (n_cons) begin
                n_phase = PH_TAG0;
            end else if (lval == '0) begin
                o_res.element_end = 1'b1;
                n_phase           = PH_TAG0;
            end else begin
                n_val_left = lval;
                n_phase    = PH_VAL;
            end
        end

        if (n_err != btp_pkg::ERR_NONE) begin
            n_phase = PH_ERR;
        end else if (i_cls.last && n_phase != PH_TAG0) begin
            n_err = btp_pkg::ERR_TRUNC;
        end
        o_res.error_code = n_err;

        // end of buffer returns everything to idle
        if (i_cls.last) begin
            n_phase    = PH_TAG0;
            n_tag_acc  = '0;
            n_tag_cnt  = '0;
            n_cons     = 1'b0;
            n_len_acc  = '0;
            n_len_left = '0;
            n_val_left = '0;
            n_err      = btp_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TAG0;
            r_tag_acc  <= '0;
            r_tag_cnt  <= '0;
            r_cons     <= 1'b0;
            r_len_acc  <= '0;
            r_len_left <= '0;
            r_val_left <= '0;
            r_err      <= btp_pkg::ERR_NONE;
        end else if (o_take) begin
            r_phase    <= n_phase;
            r_tag_acc  <= n_tag_acc;
            r_tag_cnt  <= n_tag_cnt;
            r_cons     <= n_cons;
            r_len_acc  <= n_len_acc;
            r_len_left <= n_len_left;
            r_val_left <= n_val_left;
            r_err      <= n_err;
        end
    end

endmodule

// ----- design/ber_tlv_stream_parser.sv -----
// Top level of the BER-TLV stream parser: decode front end, decode queue,
// TLV state machine and result queue. Depends on btp_pkg, btp_fifo, btp_front, btp_back.
//
//   channel   handshake                   payload
//   input     push / full                 i_in  (t_in_item)
//   result    pop / empty                 o_out (t_out_item)
//   config    i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One byte per cycle while the result side keeps popping; a pushed byte is held in the
// decode queue, then written to the result queue. The back-end FSM sets the rate.
// Reset is synchronous and empties both queues; limits return to 3.
// A stalled result side fills the result queue, then the decode queue, then
// raises full. Config is always ready.
module ber_tlv_stream_parser #(
    parameter int TAG_BYTES_MAX    = 3,
    parameter int LENGTH_BYTES_MAX = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  btp_pkg::t_in_item             i_in,
    input  logic                          pop,
    output logic                          empty,
    output btp_pkg::t_out_item            o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [btp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [btp_pkg::LIM_W-1:0]     i_cfg_data
);
    localparam int CLS_W = $bits(btp_pkg::t_cls_item);
    localparam int RES_W = $bits(btp_pkg::t_out_item);

    btp_pkg::t_cls_item        front_cls, back_cls;
    btp_pkg::t_out_item        back_res;
    logic [btp_pkg::LIM_W-1:0] tag_lim;
    logic                      cls_empty, back_take, res_full;

    assign o_cfg_ready = 1'b1;

    btp_front #(
        .TAG_BYTES_MAX    (TAG_BYTES_MAX),
        .LENGTH_BYTES_MAX (LENGTH_BYTES_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in),
        .o_cls       (front_cls),
        .o_tag_lim   (tag_lim)
    );

    btp_fifo #(
        .WIDTH (CLS_W),
        .DEPTH (2)
    ) u_cls_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cls),
        .o_full  (full),
        .i_pop   (back_take),
        .o_data  (back_cls),
        .o_empty (cls_empty)
    );

    btp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!cls_empty),
        .i_cls      (back_cls),
        .i_tag_lim  (tag_lim),
        .o_take     (back_take),
        .i_res_full (res_full),
        .o_res      (back_res)
    );

    btp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_take),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_out),
        .o_empty (empty)
    );

endmodule

// ----- sim/tlv_result_checker.sv -----
// Checker for the BER-TLV stream parser: watches the input, result and config channels,
// predicts each classified byte and compares it field by field. Depends on btp_pkg.
module tlv_result_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic                          i_full,
    input  btp_pkg::t_in_item             i_in,
    input  logic                          i_pop,
    input  logic                          i_empty,
    input  btp_pkg::t_out_item            i_out,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [btp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [btp_pkg::LIM_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TAG_CAP = 3;
    localparam int unsigned LEN_CAP = 3;
    localparam int PRINT_CAP = 100;

    typedef enum logic [2:0] {
        P_TAG_FIRST, P_TAG_MORE, P_LEN_FIRST, P_LEN_MORE, P_VALUE, P_ERROR
    } t_parse_phase;

    logic [btp_pkg::LIM_W-1:0] tag_limit_reg;
    logic [btp_pkg::LIM_W-1:0] len_limit_reg;

    t_parse_phase parse_phase;
    logic [23:0]  tag_acc;
    int unsigned  tag_seen;
    logic         in_cons;
    logic [23:0]  len_acc;
    logic [1:0]   len_due;
    logic [23:0]  val_due;
    logic [2:0]   err_hold;

    btp_pkg::t_out_item results_due[$];
    btp_pkg::t_out_item predicted;
    int        fail_total = 0;
    int        results_seen = 0;

    assign o_fail_count = fail_total;

    task automatic report(string msg);
        if (fail_total < PRINT_CAP)
            $display("%0t ns mismatch: %s", $time, msg);
        fail_total++;
    endtask

    task automatic check_field(string name, logic [23:0] got, logic [23:0] want);
        if (got !== want)
            report($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                             results_seen, name, got, want));
    endtask

    function automatic int unsigned capped_limit(logic [btp_pkg::LIM_W-1:0] r,
                                                 int unsigned cap);
        int unsigned v;
        v = (r == 0) ? 1 : r;
        return (v > cap) ? cap : v;
    endfunction

    task automatic clear_parse();
        parse_phase = P_TAG_FIRST;
        tag_acc     = '0;
        tag_seen    = 0;
        in_cons     = 1'b0;
        len_acc     = '0;
        len_due     = '0;
        val_due     = '0;
        err_hold    = btp_pkg::ERR_NONE;
    endtask

    // Classify one byte and advance the parser state.
    task automatic classify_byte(input btp_pkg::t_in_item it,
                                 output btp_pkg::t_out_item res);
        int unsigned tlim;
        int unsigned llim;
        int unsigned cnt;
        logic [7:0]  b;
        logic        have_len;
        logic [23:0] lval;
        b        = it.in_byte;
        tlim     = capped_limit(tag_limit_reg, TAG_CAP);
        llim     = capped_limit(len_limit_reg, LEN_CAP);
        have_len = 1'b0;
        lval     = '0;
        res             = '0;
        res.out_byte    = b;
        res.buffer_done = it.in_last;
        res.byte_kind   = btp_pkg::KIND_IGNORED;
        case (parse_phase)
            P_TAG_MORE: begin
                res.byte_kind   = btp_pkg::KIND_TAG;
                res.constructed = in_cons;
                tag_acc = {tag_acc[15:0], b};
                if (b[7]) begin
                    if (tag_seen + 2 >= tlim)
                        err_hold = btp_pkg::ERR_TAG_LONG;
                    else
                        tag_seen++;
                end else begin
                    res.tag_complete = 1'b1;
                    parse_phase = P_LEN_FIRST;
                end
            end
            P_LEN_FIRST: begin
                res.byte_kind   = btp_pkg::KIND_LENGTH;
                res.constructed = in_cons;
                if (b < 8'h80) begin
                    lval     = {16'h0, b};
                    have_len = 1'b1;
                end else if (b == 8'h80) begin
                    err_hold = btp_pkg::ERR_INDEF;
                end else begin
                    cnt = b[6:0];
                    if (cnt > llim) begin
                        err_hold = btp_pkg::ERR_LEN_BYTES;
                    end else begin
                        len_due     = 2'(cnt - 1);
                        len_acc     = '0;
                        parse_phase = P_LEN_MORE;
                    end
                end
            end
            P_LEN_MORE: begin
                res.byte_kind   = btp_pkg::KIND_LENGTH;
                res.constructed = in_cons;
                // a length wider than 24 bits saturates
                if (len_acc[23:16] != 0)
                    len_acc = '1;
                else
                    len_acc = {len_acc[15:0], b};
                if (len_due == 0) begin
                    lval     = len_acc;
                    have_len = 1'b1;
                end else begin
                    len_due--;
                end
            end
            P_VALUE: begin
                res.byte_kind   = btp_pkg::KIND_VALUE;
                res.constructed = in_cons;
                if (val_due <= 1) begin
                    val_due         = '0;
                    res.element_end = 1'b1;
                    parse_phase     = P_TAG_FIRST;
                end else begin
                    val_due--;
                end
            end
            P_ERROR: ;
            default: begin
                res.byte_kind     = btp_pkg::KIND_TAG;
                res.element_start = 1'b1;
                tag_acc  = {16'h0, b};
                tag_seen = 0;
                in_cons  = b[5];
                res.constructed = in_cons;
                if (b[4:0] == 5'h1F) begin
                    if (tlim <= 1)
                        err_hold = btp_pkg::ERR_TAG_LONG;
                    else
                        parse_phase = P_TAG_MORE;
                end else begin
                    res.tag_complete = 1'b1;
                    parse_phase = P_LEN_FIRST;
                end
            end
        endcase

        if (res.tag_complete)
            res.tag_value = tag_acc;

        if (have_len) begin
            res.length_complete = 1'b1;
            res.length_value    = lval;
            // constructed: descend, next byte is a new tag
            if (in_cons) begin
                parse_phase = P_TAG_FIRST;
            end else if (lval == 0) begin
                res.element_end = 1'b1;
                parse_phase = P_TAG_FIRST;
            end else begin
                val_due     = lval;
                parse_phase = P_VALUE;
            end
        end

        if (err_hold != btp_pkg::ERR_NONE)
            parse_phase = P_ERROR;
        else if (it.in_last && parse_phase != P_TAG_FIRST)
            err_hold = btp_pkg::ERR_TRUNC;
        res.error_code = err_hold;

        if (it.in_last)
            clear_parse();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tag_limit_reg = 2'd3;
            len_limit_reg = 2'd3;
            clear_parse();
            results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    btp_pkg::CFG_TAG_LIMIT: tag_limit_reg = i_cfg_data;
                    btp_pkg::CFG_LEN_LIMIT: len_limit_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_push && !i_full) begin
                classify_byte(i_in, predicted);
                results_due.insert(results_due.size(), predicted);
            end
            if (i_pop && !i_empty) begin
                if (results_due.size() == 0) begin
                    report($sformatf("result %0d with no item pending", results_seen));
                end else begin
                    predicted = results_due.pop_front();
                    check_field("out_byte", 24'(i_out.out_byte), 24'(predicted.out_byte));
                    check_field("byte_kind", 24'(i_out.byte_kind), 24'(predicted.byte_kind));
                    check_field("element_start", 24'(i_out.element_start),
                                24'(predicted.element_start));
                    check_field("tag_complete", 24'(i_out.tag_complete),
                                24'(predicted.tag_complete));
                    check_field("tag_value", i_out.tag_value, predicted.tag_value);
                    check_field("constructed", 24'(i_out.constructed),
                                24'(predicted.constructed));
                    check_field("length_complete", 24'(i_out.length_complete),
                                24'(predicted.length_complete));
                    check_field("length_value", i_out.length_value, predicted.length_value);
                    check_field("element_end", 24'(i_out.element_end),
                                24'(predicted.element_end));
                    check_field("error_code", 24'(i_out.error_code), 24'(predicted.error_code));
                    check_field("buffer_done", 24'(i_out.buffer_done),
                                24'(predicted.buffer_done));
                end
                results_seen++;
            end
        end
        o_pending = results_due.size();
    end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the BER-TLV stream parser: clock, reset, byte stimulus and verdict.
// Depends on btp_pkg, ber_tlv_stream_parser and tlv_result_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int STAGE_ITEMS  = 145;
    localparam int DRAIN_CYCLES = 8;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          push;
    logic                          full;
    btp_pkg::t_in_item             i_in;
    logic                          pop;
    logic                          empty;
    btp_pkg::t_out_item            o_out;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [btp_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [btp_pkg::LIM_W-1:0]     i_cfg_data;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int items_sent = 0;
    int tag_lim_eff = 3;
    int len_lim_eff = 3;

    logic [7:0] buf_bytes[$];

    ber_tlv_stream_parser i_dut (
        .i_clk, .i_rst_n, .push, .full, .i_in, .pop, .empty, .o_out,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    tlv_result_checker u_checker (
        .i_clk, .i_rst_n,
        .i_push(push), .i_full(full), .i_in,
        .i_pop(pop), .i_empty(empty), .i_out(o_out),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ber_tlv_stream_parser regression: fail");
            $finish;
        end
    end

    // result side: random stalls
    always @(posedge i_clk)
        pop <= i_rst_n && ($urandom_range(0, 99) >= recv_idle);

    task automatic send_item(btp_pkg::t_in_item it);
        while ($urandom_range(0, 99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= it;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_buffer();
        btp_pkg::t_in_item it;
        foreach (buf_bytes[i]) begin
            it.in_byte = buf_bytes[i];
            it.in_last = (i == buf_bytes.size() - 1);
            send_item(it);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_limits(logic [btp_pkg::LIM_W-1:0] tag_lim,
                                logic [btp_pkg::LIM_W-1:0] len_lim);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= btp_pkg::CFG_TAG_LIMIT;
        i_cfg_data  <= tag_lim;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_index <= btp_pkg::CFG_LEN_LIMIT;
        i_cfg_data  <= len_lim;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        tag_lim_eff = (tag_lim == 0) ? 1 : tag_lim;
        len_lim_eff = (len_lim == 0) ? 1 : len_lim;
    endtask

    task automatic put_byte(logic [7:0] b);
        buf_bytes.insert(buf_bytes.size(), b);
    endtask

    // extra = tag bytes after the first; zero gives a one-byte tag
    task automatic add_tag(logic cons, int extra);
        logic [7:0] b;
        b = 8'($urandom);
        b[5] = cons;
        if (extra == 0) begin
            if (b[4:0] == 5'h1F)
                b[4:0] = 5'($urandom_range(0, 30));
            put_byte(b);
        end else begin
            b[4:0] = 5'h1F;
            put_byte(b);
            repeat (extra - 1)
                put_byte(8'($urandom) | 8'h80);
            put_byte(8'($urandom) & 8'h7F);
        end
    endtask

    // nbytes zero gives the short form
    task automatic add_length(logic [23:0] len, int nbytes);
        if (nbytes == 0) begin
            put_byte({1'b0, len[6:0]});
        end else begin
            put_byte(8'h80 | 8'(nbytes));
            for (int i = nbytes - 1; i >= 0; i--)
                put_byte(len[8*i +: 8]);
        end
    endtask

    task automatic add_element();
        logic        cons;
        int          extra;
        logic [23:0] len;
        int          nb;
        cons  = ($urandom_range(0, 3) == 0);
        extra = $urandom_range(0, 1) ? $urandom_range(0, tag_lim_eff - 1) : 0;
        add_tag(cons, extra);
        if (cons) begin
            nb = $urandom_range(0, len_lim_eff);
            len = (nb == 0) ? 24'($urandom_range(0, 127)) : 24'($urandom);
            if (nb < 3)
                len = len & ((24'h1 << (nb == 0 ? 7 : 8 * nb)) - 1);
            add_length(len, nb);
        end else begin
            if ($urandom_range(0, 99) == 0) begin
                len = 24'($urandom_range(128, 160));
                nb  = $urandom_range(1, len_lim_eff);
            end else begin
                len = 24'($urandom_range(0, 6));
                nb  = $urandom_range(0, len_lim_eff);
            end
            add_length(len, nb);
            repeat (len)
                put_byte(8'($urandom));
        end
    endtask

    task automatic build_buffer();
        int k;
        buf_bytes.delete();
        k = $urandom_range(0, 99);
        if (k < 6) begin
            repeat ($urandom_range(1, 8))
                put_byte(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 5))
                add_element();
            if (k < 11) begin
                // cut the buffer short
                if (buf_bytes.size() > 1)
                    repeat ($urandom_range(1, buf_bytes.size() - 1))
                        void'(buf_bytes.pop_back());
            end else if (k < 14) begin
                add_tag(1'($urandom_range(0, 1)), tag_lim_eff);
                add_length(24'($urandom_range(0, 3)), 0);
            end else if (k < 17) begin
                add_tag(1'($urandom_range(0, 1)), 0);
                if ($urandom_range(0, 1))
                    put_byte(8'h80);
                else
                    put_byte(8'h80 | 8'($urandom_range(len_lim_eff + 1, 127)));
                repeat ($urandom_range(0, 3))
                    put_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        logic [btp_pkg::LIM_W-1:0] stage_tag[9] =
            '{2'd1, 2'd3, 2'd2, 2'd0, 2'd3, 2'd1, 2'd2, 2'd0, 2'd3};
        logic [btp_pkg::LIM_W-1:0] stage_len[9] =
            '{2'd1, 2'd3, 2'd0, 2'd2, 2'd1, 2'd3, 2'd2, 2'd0, 2'd3};
        int start;
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        pop         <= 1'b0;
        i_in        <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= btp_pkg::CFG_TAG_LIMIT;
        i_cfg_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle = 7;
        recv_idle = 66;
        // directed buffers at the reset limits
        buf_bytes = '{8'h00, 8'h00};
        send_buffer();
        buf_bytes = '{8'hFF, 8'hFF, 8'h7F, 8'h83, 8'hFF, 8'hFF, 8'hFF};
        send_buffer();
        buf_bytes = '{8'h04, 8'h80, 8'h12};
        send_buffer();
        buf_bytes = '{8'h04, 8'h84, 8'h01};
        send_buffer();
        buf_bytes = '{8'h1F, 8'h81, 8'h82, 8'h01};
        send_buffer();
        buf_bytes = '{8'h04, 8'h05, 8'hAA};
        send_buffer();
        buf_bytes = '{8'hFF};
        send_buffer();
        wait_drained();

        for (int s = 0; s < 9; s++) begin
            if (s == 3) begin
                send_idle = 66;
                recv_idle = 7;
            end else if (s == 6) begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_limits(stage_tag[s], stage_len[s]);
            start = items_sent;
            while (items_sent - start < STAGE_ITEMS) begin
                build_buffer();
                send_buffer();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("ber_tlv_stream_parser regression: pass");
        else
            $display("ber_tlv_stream_parser regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
design/btp_pkg.sv
design/btp_fifo.sv
design/btp_front.sv
design/btp_back.sv
design/ber_tlv_stream_parser.sv
sim/tlv_result_checker.sv
sim/tb.sv
